>>> hdl/rlbd_pkg.sv
// Shared types and constants of the resistor-ladder button decoder.
`timescale 1ns / 1ps
`default_nettype none

package rlbd_pkg;

    localparam int SAMPLE_BITS   = 10;
    localparam int TIME_BITS     = 32;
    localparam int SEARCH_BITS   = 16;
    localparam int NUM_WINDOWS   = 7;
    localparam int CFG_ADDR_BITS = 3;
    localparam int CFG_DATA_BITS = 4 * SAMPLE_BITS;

    localparam logic [CFG_ADDR_BITS-1:0] REG_GROUND_THRESHOLD = 3'd0;
    localparam logic [CFG_ADDR_BITS-1:0] REG_SEARCH_WINDOW    = 3'd1;
    localparam logic [CFG_ADDR_BITS-1:0] REG_WINDOWS_A_B      = 3'd2;
    localparam logic [CFG_ADDR_BITS-1:0] REG_WINDOWS_C_AB     = 3'd3;
    localparam logic [CFG_ADDR_BITS-1:0] REG_WINDOWS_AC_BC    = 3'd4;
    localparam logic [CFG_ADDR_BITS-1:0] REG_WINDOW_ABC       = 3'd5;

    localparam logic [SEARCH_BITS-1:0] SEARCH_WINDOW_RESET = 16'd50;

    typedef enum logic [2:0] {
        BTN_A   = 3'd0,
        BTN_B   = 3'd1,
        BTN_C   = 3'd2,
        BTN_AB  = 3'd3,
        BTN_AC  = 3'd4,
        BTN_BC  = 3'd5,
        BTN_ABC = 3'd6
    } t_button_code;

    // One level window: the range sits above the minimum, as in the register layout.
    typedef struct packed {
        logic [SAMPLE_BITS-1:0] rng;
        logic [SAMPLE_BITS-1:0] lo;
    } t_window;

    typedef struct packed {
        logic [SAMPLE_BITS-1:0] sample;
        logic [TIME_BITS-1:0]   now_ms;
    } t_in_req;

    typedef struct packed {
        logic                   event_valid;
        t_button_code           button_code;
        logic                   unexpected_level;
        logic [SAMPLE_BITS-1:0] classified_level;
    } t_out_req;

    typedef struct packed {
        logic         hit;
        t_button_code code;
    } t_class_result;

endpackage

`default_nettype wire

>>> hdl/rlbd_classifier.sv
// Priority match of a peak level against the seven button level windows.
`timescale 1ns / 1ps
`default_nettype none

module rlbd_classifier (
    input  wire logic [rlbd_pkg::SAMPLE_BITS-1:0]               i_level,
    input  wire rlbd_pkg::t_window [rlbd_pkg::NUM_WINDOWS-1:0]  i_windows,
    output rlbd_pkg::t_class_result                             o_result
);

    logic [rlbd_pkg::NUM_WINDOWS-1:0] match;

    // The upper bound is formed one bit wider so that it never saturates.
    always_comb begin
        for (int i = 0; i < rlbd_pkg::NUM_WINDOWS; i++) begin
            match[i] = (i_level >= i_windows[i].lo) &&
                       ({1'b0, i_level} <= ({1'b0, i_windows[i].lo} + {1'b0, i_windows[i].rng}));
        end
    end

    // Lowest index wins, so scan from the top down.
    always_comb begin
        o_result.hit  = |match;
        o_result.code = rlbd_pkg::BTN_A;
        for (int i = rlbd_pkg::NUM_WINDOWS - 1; i >= 0; i--) begin
            if (match[i]) begin
                o_result.code = rlbd_pkg::t_button_code'(3'(i));
            end
        end
    end

endmodule

`default_nettype wire

>>> hdl/resistor_ladder_button_decoder.sv
// Top level of the resistor-ladder button decoder: request channels, state and settings.
`timescale 1ns / 1ps
`default_nettype none

// Each input request is one poll of the button line: an ADC sample and the current
// time in milliseconds. Every poll yields exactly one output request, which reports
// a recognised button, an unexpected level, or nothing when no classification fell due.
// Both channels use valid and stall; a request moves when valid is high and stall low.
// The poll is captured in an input register and the whole decision, including the
// press state update and the window match, is made from that register into the
// output register whenever the output register is free. One poll is accepted every
// cycle while the receiver does not stall. When the receiver stalls, the output
// register holds its request; one further poll may sit in the input register, after
// which o_in_stall is raised until the output drains. Settings are to be written by
// the user through the plain write port while the block is idle; the block itself
// does not enforce this. Indexes beyond the register list are ignored.
// Reset clears both pipeline stages, returns the press tracker to "not pressed, nothing
// pending" and loads the register defaults (a search window of 50 ms, all else zero).

module resistor_ladder_button_decoder (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    input  wire logic                                  i_in_valid,
    output logic                                       o_in_stall,
    input  wire rlbd_pkg::t_in_req                     i_in_req,
    output logic                                       o_out_valid,
    input  wire logic                                  i_out_stall,
    output rlbd_pkg::t_out_req                         o_out_req,
    input  wire logic                                  i_cfg_we,
    input  wire logic [rlbd_pkg::CFG_ADDR_BITS-1:0]    i_cfg_addr,
    input  wire logic [rlbd_pkg::CFG_DATA_BITS-1:0]    i_cfg_data
);

    localparam int SB = rlbd_pkg::SAMPLE_BITS;
    localparam int TB = rlbd_pkg::TIME_BITS;

    // Settings registers.
    logic [SB-1:0]                                r_ground;
    logic [rlbd_pkg::SEARCH_BITS-1:0]             r_search;
    rlbd_pkg::t_window [rlbd_pkg::NUM_WINDOWS-1:0] r_windows;

    // Pipeline registers.
    logic               r_in_valid;
    rlbd_pkg::t_in_req  r_in;
    logic               r_out_valid;
    rlbd_pkg::t_out_req r_out;

    // Press tracking state.
    logic          r_pressed;
    logic          r_done;
    logic [TB-1:0] r_start;
    logic [SB-1:0] r_peak;

    logic          n_pressed;
    logic          n_done;
    logic [TB-1:0] n_start;
    logic [SB-1:0] n_peak;
    rlbd_pkg::t_out_req n_out;

    logic          out_ready;
    logic          in_ready;
    logic          advance;
    logic          pressed_now;
    logic          new_press;
    logic          release_now;
    logic [TB:0]   window_end;
    logic          in_window;
    logic          due;
    logic [SB-1:0] class_level;
    rlbd_pkg::t_class_result cls;

    // The output register frees up when it is empty or being taken; the input
    // register can take a new poll when it is empty or its contents move on.
    assign out_ready   = !r_out_valid || !i_out_stall;
    assign advance     = r_in_valid && out_ready;
    assign in_ready    = !r_in_valid || out_ready;
    assign o_in_stall  = !in_ready;
    assign o_out_valid = r_out_valid;
    assign o_out_req   = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ground  <= '0;
            r_search  <= rlbd_pkg::SEARCH_WINDOW_RESET;
            r_windows <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                rlbd_pkg::REG_GROUND_THRESHOLD: r_ground <= i_cfg_data[SB-1:0];
                rlbd_pkg::REG_SEARCH_WINDOW: r_search <= i_cfg_data[rlbd_pkg::SEARCH_BITS-1:0];
                rlbd_pkg::REG_WINDOWS_A_B: begin
                    r_windows[0] <= i_cfg_data[2*SB-1:0];
                    r_windows[1] <= i_cfg_data[4*SB-1:2*SB];
                end
                rlbd_pkg::REG_WINDOWS_C_AB: begin
                    r_windows[2] <= i_cfg_data[2*SB-1:0];
                    r_windows[3] <= i_cfg_data[4*SB-1:2*SB];
                end
                rlbd_pkg::REG_WINDOWS_AC_BC: begin
                    r_windows[4] <= i_cfg_data[2*SB-1:0];
                    r_windows[5] <= i_cfg_data[4*SB-1:2*SB];
                end
                rlbd_pkg::REG_WINDOW_ABC: r_windows[6] <= i_cfg_data[2*SB-1:0];
                default: ;
            endcase
        end
    end

    // Press detection. On a new press the start time is this poll's time, so the
    // window end is known to lie at or after now: the peak may update only if the
    // window is non-zero, and classification cannot fall due in the same poll.
    assign pressed_now = r_in.sample > r_ground;
    assign new_press   = pressed_now && !r_pressed;
    assign release_now = !pressed_now && r_pressed;
    assign window_end  = {1'b0, r_start} + {{(TB + 1 - rlbd_pkg::SEARCH_BITS){1'b0}}, r_search};
    assign in_window   = new_press ? (r_search != '0) : ({1'b0, r_in.now_ms} < window_end);
    assign due         = !r_done && !new_press && ({1'b0, r_in.now_ms} > window_end);

    // A due classification never coincides with a peak update, so the level to
    // classify is the stored peak, or zero when the button is released now.
    assign class_level = pressed_now ? r_peak : '0;

    rlbd_classifier u_classifier (
        .i_level   (class_level),
        .i_windows (r_windows),
        .o_result  (cls)
    );

    always_comb begin
        n_pressed = pressed_now;
        n_start   = new_press ? r_in.now_ms : r_start;
        n_peak    = r_peak;
        if (pressed_now && in_window && (r_in.sample > r_peak)) begin
            n_peak = r_in.sample;
        end else if (release_now) begin
            n_peak = '0;
        end
        n_done = r_done;
        if (new_press) begin
            n_done = 1'b0;
        end else if (due) begin
            n_done = 1'b1;
        end
    end

    always_comb begin
        n_out.event_valid      = due && cls.hit;
        n_out.button_code      = (due && cls.hit) ? cls.code : rlbd_pkg::BTN_A;
        n_out.unexpected_level = due && !cls.hit;
        n_out.classified_level = due ? class_level : '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_pressed   <= 1'b0;
            r_done      <= 1'b1;
            r_start     <= '0;
            r_peak      <= '0;
        end else begin
            if (in_ready) begin
                r_in_valid <= i_in_valid;
            end
            if (out_ready) begin
                r_out_valid <= r_in_valid;
            end
            if (advance) begin
                r_pressed <= n_pressed;
                r_done    <= n_done;
                r_start   <= n_start;
                r_peak    <= n_peak;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_ready && i_in_valid) begin
            r_in <= i_in_req;
        end
        if (advance) begin
            r_out <= n_out;
        end
    end

`ifndef SYNTHESIS
    // An event and an unexpected level are never reported together.
    a_event_excl : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> !(r_out.event_valid && r_out.unexpected_level))
        else $error("event and unexpected level reported together");

    // Without an event the button code reads as zero.
    a_code_idle : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out.event_valid) |-> (r_out.button_code == rlbd_pkg::BTN_A))
        else $error("button code set without an event");

    // A poll with no classification reports a zero level.
    a_level_idle : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out.event_valid && !r_out.unexpected_level)
            |-> (r_out.classified_level == '0))
        else $error("level reported without a classification");

    // The peak is only held while a press is in progress.
    a_peak_clear : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_pressed |-> (r_peak == '0))
        else $error("peak held while not pressed");
`endif

endmodule

`default_nettype wire

>>> bench/rlbd_check_pkg.sv
// Scoreboard class for the resistor-ladder button decoder bench.
`timescale 1ns / 1ps

package rlbd_check_pkg;

    import rlbd_pkg::*;

    class button_scoreboard;

        logic [SAMPLE_BITS-1:0] ground_threshold;
        logic [SEARCH_BITS-1:0] search_ms;
        t_window                level_window [NUM_WINDOWS];

        logic                   pressed;
        logic                   decided;
        logic [TIME_BITS-1:0]   press_start;
        logic [SAMPLE_BITS-1:0] peak;

        t_out_req               awaited_results [$];
        int                     errors;

        function new();
            ground_threshold = '0;
            search_ms        = SEARCH_WINDOW_RESET;
            foreach (level_window[i]) level_window[i] = '0;
            pressed     = 1'b0;
            decided     = 1'b1;
            press_start = '0;
            peak        = '0;
            errors      = 0;
        endfunction

        function void write_reg(logic [CFG_ADDR_BITS-1:0] addr,
                                logic [CFG_DATA_BITS-1:0] data);
            case (addr)
                REG_GROUND_THRESHOLD: ground_threshold = data[SAMPLE_BITS-1:0];
                REG_SEARCH_WINDOW:    search_ms        = data[SEARCH_BITS-1:0];
                REG_WINDOWS_A_B: begin
                    level_window[0] = data[2*SAMPLE_BITS-1:0];
                    level_window[1] = data[CFG_DATA_BITS-1:2*SAMPLE_BITS];
                end
                REG_WINDOWS_C_AB: begin
                    level_window[2] = data[2*SAMPLE_BITS-1:0];
                    level_window[3] = data[CFG_DATA_BITS-1:2*SAMPLE_BITS];
                end
                REG_WINDOWS_AC_BC: begin
                    level_window[4] = data[2*SAMPLE_BITS-1:0];
                    level_window[5] = data[CFG_DATA_BITS-1:2*SAMPLE_BITS];
                end
                REG_WINDOW_ABC: level_window[6] = data[2*SAMPLE_BITS-1:0];
                default: ;
            endcase
        endfunction

        // The upper bound is checked as a difference, so min plus range never saturates.
        function logic level_fits(logic [SAMPLE_BITS-1:0] level, t_window w);
            return (level >= w.lo) && ((level - w.lo) <= w.rng);
        endfunction

        function logic [TIME_BITS:0] search_end();
            logic [TIME_BITS:0] sum;
            sum = {1'b0, press_start} +
                  {{(TIME_BITS + 1 - SEARCH_BITS){1'b0}}, search_ms};
            return sum;
        endfunction

        function void note_poll(t_in_req poll);
            t_out_req           outcome;
            logic [TIME_BITS:0] now_wide;
            outcome  = '0;
            now_wide = {1'b0, poll.now_ms};
            if (poll.sample > ground_threshold) begin
                if (!pressed) begin
                    press_start = poll.now_ms;
                    pressed     = 1'b1;
                    decided     = 1'b0;
                end
                if (now_wide < search_end() && poll.sample > peak)
                    peak = poll.sample;
            end else if (pressed) begin
                peak    = '0;
                pressed = 1'b0;
            end
            if (!decided && now_wide > search_end()) begin
                outcome.classified_level = peak;
                outcome.unexpected_level = 1'b1;
                for (int i = 0; i < NUM_WINDOWS; i++) begin
                    if (!outcome.event_valid && level_fits(peak, level_window[i])) begin
                        outcome.event_valid      = 1'b1;
                        outcome.button_code      = t_button_code'(3'(i));
                        outcome.unexpected_level = 1'b0;
                    end
                end
                decided = 1'b1;
            end
            awaited_results.push_back(outcome);
        endfunction

        function void check_result(t_out_req got);
            t_out_req want;
            if (awaited_results.size() == 0) begin
                $error("result request with no poll waiting: %p", got);
                errors++;
                return;
            end
            want = awaited_results.pop_front();
            if (got.event_valid !== want.event_valid) begin
                $error("event_valid: expected %0d, got %0d", want.event_valid, got.event_valid);
                errors++;
            end
            if (got.button_code !== want.button_code) begin
                $error("button_code: expected %0d, got %0d", want.button_code, got.button_code);
                errors++;
            end
            if (got.unexpected_level !== want.unexpected_level) begin
                $error("unexpected_level: expected %0d, got %0d",
                       want.unexpected_level, got.unexpected_level);
                errors++;
            end
            if (got.classified_level !== want.classified_level) begin
                $error("classified_level: expected %0d, got %0d",
                       want.classified_level, got.classified_level);
                errors++;
            end
        endfunction

        function int outstanding();
            return awaited_results.size();
        endfunction

    endclass

endpackage

>>> bench/resistor_ladder_button_decoder_test.sv
// Self-checking bench for the resistor-ladder button decoder.
`timescale 1ns / 1ps

// The bench plays a keypad polled by a host: each input request carries one ADC
// sample and a millisecond time stamp, and each poll yields one result request.
// A scoreboard object predicts every result from its own copy of the press state
// and of the settings, and compares the results in order, field by field.
// After a short directed part, phases of random press sequences follow, each
// phase with its own settings, among them the extremes of threshold and search
// window. Settings are only written while the decoder is idle.

module resistor_ladder_button_decoder_test;

    import rlbd_pkg::*;
    import rlbd_check_pkg::*;

    localparam int     HALF_NS      = 2;
    localparam int     RESET_CYCLES = 8;
    localparam int     LATENCY      = 2;
    localparam int     RANDOM_POLLS = 2000;
    localparam int     IDLE_PCT     = 16;
    localparam int     SAMPLE_MAX   = (1 << SAMPLE_BITS) - 1;
    localparam longint TIME_MAX     = 64'hFFFF_FFFF;
    localparam longint TIMEOUT_NS   = 64'd4_000_000;

    logic                     clk       = 1'b0;
    logic                     rst_n     = 1'b0;
    logic                     in_valid  = 1'b0;
    logic                     in_stall;
    t_in_req                  in_req    = '0;
    logic                     out_valid;
    logic                     out_stall = 1'b0;
    t_out_req                 out_req;
    logic                     cfg_we    = 1'b0;
    logic [CFG_ADDR_BITS-1:0] cfg_addr  = '0;
    logic [CFG_DATA_BITS-1:0] cfg_data  = '0;

    // When set, neither side idles: this gives one long back-to-back stretch.
    logic                     calm      = 1'b0;
    logic [TIME_BITS-1:0]     clock_ms  = '0;
    int                       polls_sent = 0;
    t_window                  window_plan [NUM_WINDOWS];
    button_scoreboard         sb;

    always begin
        #HALF_NS clk = 1'b1;
        #HALF_NS clk = 1'b0;
    end

    resistor_ladder_button_decoder uut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_req    (in_req),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_req   (out_req),
        .i_cfg_we    (cfg_we),
        .i_cfg_addr  (cfg_addr),
        .i_cfg_data  (cfg_data)
    );

    // The receiver stalls at random; the stall changes only at the falling edge.
    always @(negedge clk) begin
        out_stall <= !calm && ($urandom_range(99) < IDLE_PCT);
    end

    // A result request is taken at a rising edge with valid high and stall low.
    always @(posedge clk) begin
        if (rst_n && out_valid && !out_stall)
            sb.check_result(out_req);
    end

    // Guard against a hang: whatever state the run is in, it ends here.
    initial begin
        #(TIMEOUT_NS);
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    function automatic longint lmin(longint a, longint b);
        return (a < b) ? a : b;
    endfunction

    // A sample strictly above the threshold; callers make sure one exists.
    function automatic logic [SAMPLE_BITS-1:0] level_above();
        return SAMPLE_BITS'($urandom_range(SAMPLE_MAX, int'(sb.ground_threshold) + 1));
    endfunction

    function automatic logic [SAMPLE_BITS-1:0] level_below();
        return SAMPLE_BITS'($urandom_range(int'(sb.ground_threshold), 0));
    endfunction

    // A level a little under the target, but still above the threshold, so
    // that the peak never exceeds the target whichever order the samples come in.
    function automatic logic [SAMPLE_BITS-1:0] near_level(int target);
        int slack;
        slack = int'(lmin(target - int'(sb.ground_threshold) - 1, 20));
        return SAMPLE_BITS'(target - int'($urandom_range(slack, 0)));
    endfunction

    // Most targets fall inside one of the configured windows, so that button
    // events are common; the rest land anywhere above the threshold.
    function automatic int pick_target();
        int      lvl;
        t_window w;
        if ($urandom_range(9) < 7) begin
            w   = sb.level_window[$urandom_range(NUM_WINDOWS - 1)];
            lvl = int'(w.lo) + int'($urandom_range(int'(w.rng), 0));
            if (lvl > SAMPLE_MAX)
                lvl = SAMPLE_MAX;
        end else begin
            lvl = int'(level_above());
        end
        if (lvl <= int'(sb.ground_threshold))
            lvl = int'(level_above());
        return lvl;
    endfunction

    // Offers one poll request and holds it until the decoder takes it. The sender
    // may idle first; valid is raised only once per request, never dropped and
    // raised again within the same step.
    task automatic send_poll(input logic [SAMPLE_BITS-1:0] sample,
                             input logic [TIME_BITS-1:0] now);
        t_in_req poll;
        poll.sample = sample;
        poll.now_ms = now;
        while (!calm && ($urandom_range(99) < IDLE_PCT)) begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        in_req   <= poll;
        do @(posedge clk); while (in_stall);
        sb.note_poll(poll);
        polls_sent++;
        @(negedge clk);
    endtask

    // Stops sending and waits until every predicted result has been taken, plus
    // the pipeline latency, so that the decoder is idle afterwards.
    task automatic hold_off();
        in_valid <= 1'b0;
        @(negedge clk);
        while (sb.outstanding() != 0)
            @(negedge clk);
        repeat (LATENCY + 2) @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_ADDR_BITS-1:0] addr,
                             input logic [CFG_DATA_BITS-1:0] data);
        cfg_we   <= 1'b1;
        cfg_addr <= addr;
        cfg_data <= data;
        @(negedge clk);
        cfg_we   <= 1'b0;
        sb.write_reg(addr, data);
        @(negedge clk);
    endtask

    // Writes the seven planned windows; the unused upper bits of the last
    // register carry junk, which the decoder must ignore.
    task automatic write_windows();
        write_reg(REG_WINDOWS_A_B,   {window_plan[1], window_plan[0]});
        write_reg(REG_WINDOWS_C_AB,  {window_plan[3], window_plan[2]});
        write_reg(REG_WINDOWS_AC_BC, {window_plan[5], window_plan[4]});
        write_reg(REG_WINDOW_ABC,    {(2 * SAMPLE_BITS)'($urandom), window_plan[6]});
    endtask

    // Lays windows out above the threshold in rising order (the first is at times
    // zero); some overlap their predecessor so that the priority order matters.
    task automatic plan_windows();
        int lo;
        int rng;
        int cursor;
        cursor = int'(sb.ground_threshold) + 1;
        for (int i = 0; i < NUM_WINDOWS; i++) begin
            if (i > 0 && $urandom_range(3) == 0)
                lo = int'(window_plan[i-1].lo) + int'($urandom_range(int'(window_plan[i-1].rng), 0));
            else if (i == 0 && $urandom_range(7) == 0)
                lo = 0;
            else
                lo = cursor + int'($urandom_range(15));
            if (lo > SAMPLE_MAX)
                lo = SAMPLE_MAX;
            rng = (i == NUM_WINDOWS - 1 && $urandom_range(3) == 0) ?
                  int'($urandom_range(SAMPLE_MAX)) : int'($urandom_range(60));
            window_plan[i].lo  = SAMPLE_BITS'(lo);
            window_plan[i].rng = SAMPLE_BITS'(rng);
            cursor = lo + rng + 1;
        end
    endtask

    // One press as a keypad gives it: the press, a few samples within the
    // search window, sometimes one exactly at its end, the poll at which the
    // classification falls due, a few held polls and the release.
    task automatic press_sequence();
        longint start;
        longint win_end;
        longint t;
        int     target;
        logic   released;
        if ($urandom_range(7) == 0)
            clock_ms = $urandom;
        target   = pick_target();
        start    = longint'(clock_ms);
        win_end  = start + longint'(sb.search_ms);
        released = 1'b0;
        send_poll($urandom_range(1) ? SAMPLE_BITS'(target) : near_level(target),
                  TIME_BITS'(start));
        t = start;
        repeat ($urandom_range(3)) begin
            if (lmin(win_end, TIME_MAX) - t > 1) begin
                t = t + 1 +
                    longint'($urandom_range(int'(lmin(lmin(win_end, TIME_MAX) - t - 2, 16))));
                send_poll($urandom_range(2) == 0 ? SAMPLE_BITS'(target) : near_level(target),
                          TIME_BITS'(t));
            end
        end
        if ($urandom_range(4) == 0 && win_end <= TIME_MAX) begin
            t = win_end;
            send_poll(level_above(), TIME_BITS'(t));
        end
        if (win_end + 8 <= TIME_MAX) begin
            t = win_end + 1 + longint'($urandom_range(7));
            if ($urandom_range(4) == 0) begin
                // The release lands on the very poll at which the peak is classified.
                send_poll(level_below(), TIME_BITS'(t));
                released = 1'b1;
            end else begin
                send_poll(level_above(), TIME_BITS'(t));
                repeat ($urandom_range(2)) begin
                    t = lmin(t + 1 + longint'($urandom_range(3)), TIME_MAX);
                    send_poll(level_above(), TIME_BITS'(t));
                end
            end
        end
        if (!released) begin
            t = lmin(t + 1, TIME_MAX);
            send_poll(level_below(), TIME_BITS'(t));
        end
        clock_ms = TIME_BITS'(t + 1 + longint'($urandom_range(100)));
    endtask

    // Polls that break the pattern: any level, and sometimes any time at all.
    task automatic noise_polls();
        repeat ($urandom_range(3, 1)) begin
            send_poll(SAMPLE_BITS'($urandom_range(SAMPLE_MAX)),
                      $urandom_range(1) ? TIME_BITS'($urandom) : clock_ms);
            clock_ms = clock_ms + $urandom_range(20);
        end
    endtask

    // Settings of one random phase. The style cycles so that every extreme
    // comes round: no threshold with no search window, the longest window,
    // a threshold that nothing can exceed, and wholly random register words.
    task automatic configure_phase(input int style);
        logic [SAMPLE_BITS-1:0] thr;
        logic [SEARCH_BITS-1:0] search;
        case (style)
            0: begin
                thr    = SAMPLE_BITS'($urandom_range(300));
                search = SEARCH_BITS'($urandom_range(20, 1));
            end
            1: begin
                thr    = '0;
                search = '0;
            end
            2: begin
                thr    = SAMPLE_BITS'($urandom_range(400));
                search = '1;
            end
            3: begin
                thr    = SAMPLE_BITS'($urandom_range(200));
                search = SEARCH_BITS'($urandom_range(40, 1));
            end
            4: begin
                thr    = SAMPLE_BITS'(SAMPLE_MAX);
                search = SEARCH_BITS'($urandom_range(30));
            end
            default: begin
                thr    = SAMPLE_BITS'($urandom);
                search = SEARCH_BITS'($urandom);
            end
        endcase
        write_reg(REG_GROUND_THRESHOLD, {(CFG_DATA_BITS - SAMPLE_BITS)'({$urandom, $urandom}), thr});
        write_reg(REG_SEARCH_WINDOW, {(CFG_DATA_BITS - SEARCH_BITS)'({$urandom, $urandom}), search});
        if (style >= 4) begin
            write_reg(REG_WINDOWS_A_B,   CFG_DATA_BITS'({$urandom, $urandom}));
            write_reg(REG_WINDOWS_C_AB,  CFG_DATA_BITS'({$urandom, $urandom}));
            write_reg(REG_WINDOWS_AC_BC, CFG_DATA_BITS'({$urandom, $urandom}));
            write_reg(REG_WINDOW_ABC,    CFG_DATA_BITS'({$urandom, $urandom}));
        end else begin
            plan_windows();
            write_windows();
        end
    endtask

    initial begin
        int                     phase;
        int                     style;
        int                     quota;
        int                     phase_start;
        int                     random_sent;
        int                     drain_cycles;
        longint                 t;
        logic [SAMPLE_BITS-1:0] button_levels [NUM_WINDOWS];

        sb = new();
        random_sent = 0;
        repeat (RESET_CYCLES) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Reset settings: a peak of 500 found early, a louder sample exactly at
        // the window end which must not count, then the classification of 500
        // against all-zero windows, which flags an unexpected level.
        send_poll(10'd500, 32'd0);
        send_poll(10'd1023, 32'd50);
        send_poll(10'd200, 32'd51);
        send_poll(10'd0, 32'd60);
        hold_off();

        // Seven separate windows, one button each, the last reaching past the
        // sample scale. Each button is pressed at a window edge, but C inside its window.
        window_plan[0] = '{rng: 10'd49,   lo: 10'd200};
        window_plan[1] = '{rng: 10'd49,   lo: 10'd250};
        window_plan[2] = '{rng: 10'd49,   lo: 10'd300};
        window_plan[3] = '{rng: 10'd49,   lo: 10'd350};
        window_plan[4] = '{rng: 10'd49,   lo: 10'd400};
        window_plan[5] = '{rng: 10'd49,   lo: 10'd450};
        window_plan[6] = '{rng: 10'd1023, lo: 10'd500};
        write_reg(REG_GROUND_THRESHOLD, CFG_DATA_BITS'(100));
        write_reg(REG_SEARCH_WINDOW, CFG_DATA_BITS'(1));
        write_windows();
        button_levels = '{10'd200, 10'd299, 10'd310, 10'd399, 10'd400, 10'd499, 10'd1023};
        t = 1000;
        for (int i = 0; i < NUM_WINDOWS; i++) begin
            send_poll(button_levels[i], TIME_BITS'(t));
            send_poll(10'd101, TIME_BITS'(t + 2));
            send_poll(10'd100, TIME_BITS'(t + 3));
            t = t + 10;
        end
        // Release on the poll where the classification falls due: level 0 is classified.
        send_poll(10'd700, TIME_BITS'(t));
        send_poll(10'd0, TIME_BITS'(t + 5));
        hold_off();

        // A press so late that the end of its search window lies beyond the
        // 32-bit time range: it can never be classified.
        write_reg(REG_SEARCH_WINDOW, CFG_DATA_BITS'(16'hFFFF));
        send_poll(10'd900, 32'hFFFF_FFF0);
        send_poll(10'd0, 32'hFFFF_FFFF);

        // Random phases. Each begins with the sender paused until every result
        // has come back, so that the new settings find the decoder idle.
        phase = 0;
        while (random_sent < RANDOM_POLLS) begin
            hold_off();
            style = phase % 6;
            configure_phase(style);
            calm        = (style == 3);
            quota       = (sb.ground_threshold == SAMPLE_BITS'(SAMPLE_MAX)) ? 40 : 250;
            phase_start = polls_sent;
            while (polls_sent - phase_start < quota) begin
                if ($urandom_range(4) == 0 || sb.ground_threshold == SAMPLE_BITS'(SAMPLE_MAX))
                    noise_polls();
                else
                    press_sequence();
            end
            random_sent += polls_sent - phase_start;
            phase++;
        end
        calm = 1'b0;

        in_valid <= 1'b0;
        drain_cycles = 0;
        while (sb.outstanding() != 0 && drain_cycles < 10000) begin
            @(negedge clk);
            drain_cycles++;
        end
        repeat (LATENCY + 4) @(negedge clk);
        if (sb.outstanding() != 0)
            $error("%0d poll results never arrived", sb.outstanding());
        if (sb.errors == 0 && sb.outstanding() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

>>> filelist.f
hdl/rlbd_pkg.sv
hdl/rlbd_classifier.sv
hdl/resistor_ladder_button_decoder.sv
bench/rlbd_check_pkg.sv
bench/resistor_ladder_button_decoder_test.sv
